// ===== rtl/finger_presence_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// finger_presence_detector_top assertion macros
// clocked assertions with async reset disable, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef FINGER_PRESENCE_DETECTOR_TOP_ASSERT_SVH
`define FINGER_PRESENCE_DETECTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define FPD_ASSERT(lbl, prop, msg)
`define FPD_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg
// shared widths, register codes, reset values and beat types
// ----------------------------------------------------------------------------
package fpd_pkg;

	localparam int IR_W        = 18;
	localparam int STB_W       = 4;
	localparam int BATCH_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 18;
	localparam int WINDOW_DEPTH_DEF = 100;
	localparam int MIN_SAMPLES = 10;

	localparam logic [IR_W-1:0]    LEVEL_RST  = IR_W'(15000);
	localparam logic [IR_W-1:0]    SWING_RST  = IR_W'(800);
	localparam logic [STB_W-1:0]   STABLE_RST = STB_W'(2);
	localparam logic [BATCH_W-1:0] BATCH_RST  = BATCH_W'(20);
	localparam logic [IR_W-1:0]    IR_MAX     = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL  = 2'd0,
		CFG_SWING  = 2'd1,
		CFG_STABLE = 2'd2,
		CFG_BATCH  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_SAMPLE  = 1'b0,
		ACT_RESTART = 1'b1
	} action_t;

	typedef struct packed {
		action_t         action;
		logic [IR_W-1:0] ir_sample;
	} fpd_in_t;

	typedef struct packed {
		logic            finger_now;
		logic            finger_stable;
		logic            compute_ready;
		logic [IR_W-1:0] ir_mean;
		logic [IR_W-1:0] ir_swing;
	} fpd_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/fpd_win_mem.sv =====
// ----------------------------------------------------------------------------
// fpd_win_mem
// sample window storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fpd_win_mem #(
	parameter int DEPTH = fpd_pkg::WINDOW_DEPTH_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [PTR_W-1:0]        wr_addr,
	input  logic [fpd_pkg::IR_W-1:0] wr_data,
	input  logic                    rd_en,
	input  logic [PTR_W-1:0]        rd_addr,
	output logic [fpd_pkg::IR_W-1:0] rd_data
);
	import fpd_pkg::*;

	logic [IR_W-1:0] mem_q [DEPTH];
	logic [IR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fpd_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_W-1:0]    dividend,
	input  logic [DEN_W-1:0]    divisor,
	output logic [NUM_W-1:0]    quotient,
	output fpd_pkg::div_stat_t  stat
);
	import fpd_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  dvs_q;
	logic [NUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    diff;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], ~diff[DEN_W]};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/finger_presence_detector_top.sv =====
// A sample beat that closes a batch starts an evaluation: the block walks the
// samples held (n, up to WINDOW_DEPTH) through the single read port of the window
// memory, one per cycle, and divides the sum by n with a one-bit-per-cycle divider;
// no new beat is taken until the evaluation is done. With fewer than ten samples
// held the scan and the divide are skipped. A restart beat starts no evaluation. No
// clearing pass after reset. A result waits in an output register while new beats
// come in; an evaluation that finds that register still full holds in its last state
// until the waiting result is taken.
// ----------------------------------------------------------------------------
// finger_presence_detector_top
// infrared window statistics and finger presence / stability evaluation
// ----------------------------------------------------------------------------
`include "finger_presence_detector_top_assert.svh"

module finger_presence_detector_top #(
	parameter int WINDOW_DEPTH = fpd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fpd_pkg::fpd_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fpd_pkg::fpd_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  fpd_pkg::cfg_reg_t              cfg_index,
	input  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fpd_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = IR_W + CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [IR_W-1:0]    level_q;
	logic [IR_W-1:0]    swing_thr_q;
	logic [STB_W-1:0]   need_q;
	logic [BATCH_W-1:0] batch_q;
	logic [PTR_W-1:0]   wp_q;
	logic [CNT_W-1:0]   held_q;
	logic [BATCH_W-1:0] bpos_q;
	logic [STB_W-1:0]   stb_cnt_q;
	logic [PTR_W-1:0]   addr_q;
	logic [CNT_W-1:0]   left_q;
	logic               rd_vld_s1;
	logic [SUM_W-1:0]   sum_q;
	logic [IR_W-1:0]    max_q;
	logic [IR_W-1:0]    min_q;
	logic [IR_W-1:0]    mean_q;
	logic [IR_W-1:0]    swing_q;
	logic               div_start_q;
	logic               out_valid_q;
	fpd_out_t           out_q;

	logic               in_acc;
	logic               smp_acc;
	logic               rd_en;
	logic [IR_W-1:0]    rd_data;
	logic [SUM_W-1:0]   quotient;
	div_stat_t          div_stat;
	logic               now;
	logic [STB_W-1:0]   cnt_new;
	logic               stable;
	logic               out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign smp_acc   = in_acc && (in_data.action == ACT_SAMPLE);
	assign cfg_ready = 1'b1;
	assign rd_en     = (state_q == ST_SCAN) && (left_q != '0);
	assign out_free  = !out_valid_q || out_ready;

	assign now     = (mean_q > level_q) && (swing_q > swing_thr_q);
	assign cnt_new = !now ? '0 : (stb_cnt_q < need_q) ? stb_cnt_q + 1'b1 : stb_cnt_q;
	assign stable  = cnt_new >= need_q;

	fpd_win_mem #(
		.DEPTH (WINDOW_DEPTH),
		.PTR_W (PTR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (smp_acc),
		.wr_addr (wp_q),
		.wr_data (in_data.ir_sample),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	fpd_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (held_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_RST;
			swing_thr_q <= SWING_RST;
			need_q      <= STABLE_RST;
			batch_q     <= BATCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL:  level_q     <= cfg_data[IR_W-1:0];
				CFG_SWING:  swing_thr_q <= cfg_data[IR_W-1:0];
				CFG_STABLE: need_q      <= cfg_data[STB_W-1:0];
				CFG_BATCH:  batch_q     <= cfg_data[BATCH_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath accumulators, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EVAL: begin
				sum_q   <= '0;
				max_q   <= '0;
				min_q   <= IR_MAX;
				mean_q  <= '0;
				swing_q <= '0;
			end
			ST_SCAN: begin
				if (rd_vld_s1) begin
					sum_q <= sum_q + SUM_W'(rd_data);
					if (rd_data > max_q) max_q <= rd_data;
					if (rd_data < min_q) min_q <= rd_data;
				end else if (left_q == '0) begin
					swing_q <= max_q - min_q;
				end
			end
			ST_DIV: begin
				if (div_stat.done) mean_q <= quotient[IR_W-1:0];
			end
			default: ;
		endcase
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			held_q      <= '0;
			bpos_q      <= '0;
			stb_cnt_q   <= '0;
			addr_q      <= '0;
			left_q      <= '0;
			rd_vld_s1   <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			rd_vld_s1   <= rd_en;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.action == ACT_RESTART) begin
						wp_q      <= '0;
						held_q    <= '0;
						bpos_q    <= '0;
						stb_cnt_q <= '0;
					end else if (smp_acc) begin
						wp_q <= (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						if (held_q != CNT_W'(WINDOW_DEPTH)) held_q <= held_q + 1'b1;
						if (({1'b0, bpos_q} + 1'b1) < {1'b0, batch_q}) begin
							bpos_q <= bpos_q + 1'b1;
						end else begin
							bpos_q  <= '0;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (held_q >= CNT_W'(MIN_SAMPLES)) begin
						addr_q  <= (held_q == CNT_W'(WINDOW_DEPTH)) ? wp_q : '0;
						left_q  <= held_q;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= (addr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : addr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end else if (!rd_vld_s1) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						stb_cnt_q           <= cnt_new;
						out_q.finger_now    <= now;
						out_q.finger_stable <= stable;
						out_q.compute_ready <= stable && (held_q == CNT_W'(WINDOW_DEPTH));
						out_q.ir_mean       <= mean_q;
						out_q.ir_swing      <= swing_q;
						out_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FPD_ASSERT(a_held_bound, held_q <= CNT_W'(WINDOW_DEPTH), "samples held beyond depth")
	`FPD_ASSERT_IMP(a_fill_ptr, held_q < CNT_W'(WINDOW_DEPTH), CNT_W'(wp_q) == held_q, "wp off count")
	`FPD_ASSERT_IMP(a_rd_scan, rd_vld_s1, state_q == ST_SCAN, "window read data outside scan")
	`FPD_ASSERT_IMP(a_div_done, div_stat.done, state_q == ST_DIV, "divider done outside divide")
	`FPD_ASSERT_IMP(a_fin_load, state_q == ST_FIN && out_free, ##1 out_valid, "result not loaded")

endmodule

// ===== sim/finger_presence_detector_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// finger_presence_detector_top_tb
// Drives infrared sample and restart beats through the valid/ready input channel
// and programs the four registers over the config channel between phases.
// A behavioral copy of the window statistics predicts each evaluation result.
// Every beat that leaves the block is checked against the oldest prediction.
// Both sides stall at random, except in one phase that runs without gaps.
// ----------------------------------------------------------------------------
module finger_presence_detector_top_tb;
	import fpd_pkg::*;

	localparam int WINDOW = WINDOW_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fpd_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fpd_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = CFG_LEVEL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fpd_in_t pending_beats[$];
	fpd_out_t expected_results[$];
	fpd_out_t want;
	bit steady_run = 1'b0;

	// shadow of the block state and registers
	logic [IR_W-1:0] ir_window [WINDOW];
	int unsigned wr_ptr = 0;
	int unsigned held_cnt = 0;
	int unsigned batch_cnt = 0;
	int unsigned stable_cnt = 0;
	logic [IR_W-1:0] lvl_thr = LEVEL_RST;
	logic [IR_W-1:0] swg_thr = SWING_RST;
	logic [STB_W-1:0] stab_need = STABLE_RST;
	logic [BATCH_W-1:0] batch_len = BATCH_RST;

	int errors = 0;
	int beats_sent = 0;
	int restarts = 0;
	int results_checked = 0;
	int finger_hits = 0;
	int stable_hits = 0;
	int ready_hits = 0;
	int settings_used = 0;

	finger_presence_detector_top #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic predict_presence(input fpd_in_t beat);
		int unsigned n, pos, total, hi, lo, mean, swing;
		fpd_out_t res;
		if (beat.action == ACT_RESTART) begin
			wr_ptr = 0;
			held_cnt = 0;
			batch_cnt = 0;
			stable_cnt = 0;
			restarts++;
			return;
		end
		ir_window[wr_ptr] = beat.ir_sample;
		wr_ptr = (wr_ptr + 1) % WINDOW;
		if (held_cnt < WINDOW)
			held_cnt++;
		if (batch_cnt + 1 < batch_len) begin
			batch_cnt++;
			return;
		end
		batch_cnt = 0;
		n = held_cnt;
		res = '0;
		if (n >= MIN_SAMPLES) begin
			total = 0;
			hi = 0;
			lo = IR_MAX;
			pos = (wr_ptr + WINDOW - n) % WINDOW;
			repeat (n) begin
				total += ir_window[pos];
				if (ir_window[pos] > hi)
					hi = ir_window[pos];
				if (ir_window[pos] < lo)
					lo = ir_window[pos];
				pos = (pos + 1) % WINDOW;
			end
			mean = total / n;
			swing = hi - lo;
			res.ir_mean = IR_W'(mean);
			res.ir_swing = IR_W'(swing);
			res.finger_now = (mean > lvl_thr) && (swing > swg_thr);
		end
		if (res.finger_now) begin
			if (stable_cnt < stab_need)
				stable_cnt++;
		end else begin
			stable_cnt = 0;
		end
		res.finger_stable = stable_cnt >= stab_need;
		res.compute_ready = res.finger_stable && (held_cnt >= WINDOW);
		expected_results.push_back(res);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_presence(in_data);
				beats_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && (steady_run || $urandom_range(99) >= 13)) begin
					in_valid <= 1'b1;
					in_data <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected, got %p", $time, out_data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_data !== want) begin
						$display("%0t: mismatch, expected now=%0d stable=%0d ready=%0d mean=%0d swing=%0d",
							$time, want.finger_now, want.finger_stable, want.compute_ready,
							want.ir_mean, want.ir_swing);
						$display("%0t:           actual now=%0d stable=%0d ready=%0d mean=%0d swing=%0d",
							$time, out_data.finger_now, out_data.finger_stable,
							out_data.compute_ready, out_data.ir_mean, out_data.ir_swing);
						errors++;
					end
					results_checked++;
					finger_hits += out_data.finger_now;
					stable_hits += out_data.finger_stable;
					ready_hits += out_data.compute_ready;
				end
			end
			out_ready <= steady_run || ($urandom_range(99) >= 13);
		end
	end

	task automatic wait_idle();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [IR_W-1:0] lvl, input logic [IR_W-1:0] swg,
		input logic [STB_W-1:0] stab, input logic [BATCH_W-1:0] bat);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_DATA_W-1:0] junk;
		cfg_reg_t idx;
		int i;
		wait_idle();
		// unused upper bits of the narrow registers get random fill half the time
		junk = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
		vals[0] = lvl;
		vals[1] = swg;
		vals[2] = {junk[CFG_DATA_W-1:STB_W], stab};
		vals[3] = {junk[CFG_DATA_W-1:BATCH_W], bat};
		idx = CFG_LEVEL;
		cfg_valid <= 1'b1;
		for (i = 0; i < 4; i++) begin
			cfg_index <= idx;
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				CFG_LEVEL: lvl_thr = vals[i];
				CFG_SWING: swg_thr = vals[i];
				CFG_STABLE: stab_need = vals[i][STB_W-1:0];
				CFG_BATCH: batch_len = vals[i][BATCH_W-1:0];
				default: ;
			endcase
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic queue_beat(input action_t act, input logic [IR_W-1:0] value);
		fpd_in_t beat;
		beat.action = act;
		beat.ir_sample = value;
		pending_beats.push_back(beat);
	endtask

	// one stretch of samples: a pulse above the thresholds, one near them, flat, noise or rails
	task automatic queue_segment(input int len);
		int mode, base, amp, v;
		mode = $urandom_range(99);
		base = 0;
		amp = 0;
		if (mode < 45) begin
			base = int'(lvl_thr) + 1 + int'($urandom_range(4000));
			amp = int'(swg_thr) + 1 + int'($urandom_range(4000));
		end else if (mode < 65) begin
			base = int'(lvl_thr) - 2000 + int'($urandom_range(4000));
			amp = int'(swg_thr) - 500 + int'($urandom_range(1000));
			if (amp < 0)
				amp = 0;
		end else if (mode < 75) begin
			base = int'($urandom_range(IR_MAX));
		end
		repeat (len) begin
			if (mode < 75)
				v = base - amp / 2 + int'($urandom_range(amp));
			else if (mode < 90)
				v = int'($urandom_range(IR_MAX));
			else
				v = $urandom_range(1) ? int'(IR_MAX) : 0;
			if (v < 0)
				v = 0;
			else if (v > int'(IR_MAX))
				v = IR_MAX;
			queue_beat(ACT_SAMPLE, IR_W'(v));
		end
	endtask

	task automatic queue_phase(input int count, input bit allow_restart);
		int queued, len;
		queued = 0;
		while (queued < count) begin
			if (allow_restart && $urandom_range(99) < 12) begin
				queue_beat(ACT_RESTART, IR_W'($urandom));
				len = $urandom_range(1, 14);
			end else begin
				len = $urandom_range(5, 60);
			end
			queue_segment(len);
			queued += len;
		end
	endtask

	initial begin
		int ph, r;
		logic [IR_W-1:0] lvl, swg;
		logic [STB_W-1:0] stab;
		logic [BATCH_W-1:0] bat;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: batch of zero, stable needed zero, too few samples, rails
		program_regs(LEVEL_RST, SWING_RST, '0, '0);
		queue_beat(ACT_RESTART, IR_MAX);
		for (ph = 0; ph < 9; ph++)
			queue_beat(ACT_SAMPLE, ph[0] ? '0 : IR_MAX);
		queue_beat(ACT_SAMPLE, '0);
		queue_beat(ACT_SAMPLE, IR_MAX);
		queue_beat(ACT_SAMPLE, IR_W'(1));
		queue_beat(ACT_RESTART, '0);
		queue_beat(ACT_SAMPLE, IR_W'(18'h2AAAA));
		queue_beat(ACT_SAMPLE, IR_W'(18'h15555));
		queue_beat(ACT_RESTART, IR_W'(18'h15555));

		program_regs(LEVEL_RST, SWING_RST, STABLE_RST, BATCH_RST);
		queue_phase(120, 1'b1);
		// count climbs to the top, then a long batch stays open with no evaluation
		program_regs('0, '0, 4'd15, 8'd1);
		queue_phase(110, 1'b0);
		program_regs(IR_MAX, IR_MAX, 4'd1, 8'd255);
		queue_phase(105, 1'b0);
		// batch lowered and stable needed cut below the top count while a batch and a count are in flight
		program_regs('0, '0, 4'd4, 8'd5);
		queue_phase(60, 1'b0);
		program_regs(IR_MAX, '0, '0, 8'd3);
		queue_phase(80, 1'b1);

		for (ph = 0; ph < 8; ph++) begin
			r = $urandom_range(99);
			lvl = (r < 80) ? IR_W'($urandom_range(60000)) : IR_W'($urandom_range(IR_MAX));
			r = $urandom_range(99);
			swg = (r < 80) ? IR_W'($urandom_range(6000)) : IR_W'($urandom_range(IR_MAX));
			stab = STB_W'($urandom_range(15));
			r = $urandom_range(99);
			if (r < 70)
				bat = BATCH_W'($urandom_range(1, 25));
			else if (r < 85)
				bat = '0;
			else
				bat = BATCH_W'($urandom_range(26, 255));
			program_regs(lvl, swg, stab, bat);
			steady_run <= (ph == 3);
			queue_phase(75, 1'b1);
		end

		wait_idle();
		errors += expected_results.size();
		$display("%0d beats (%0d restarts) over %0d register settings, %0d results checked",
			beats_sent, restarts, settings_used, results_checked);
		$display("finger seen %0d times, stable %0d, compute ready %0d",
			finger_hits, stable_hits, ready_hits);
		if (errors == 0)
			$display("finger_presence_detector_top_tb OK");
		else
			$display("finger_presence_detector_top_tb NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("finger_presence_detector_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_win_mem.sv
rtl/fpd_div.sv
rtl/finger_presence_detector_top.sv
sim/finger_presence_detector_top_tb.sv
